@@ src/assert_macros.svh @@
// Shared assertion macros for the header line parser checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed: property violated");

// Check that a signal keeps its value into the next cycle after a condition.
`define ASSERT_HOLD(lbl, clk, rst_n, cond, sig) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> $stable(sig)) \
    else $error("assertion failed: signal changed while held");

`endif

@@ src/hhlp_pkg.sv @@
package hhlp_pkg;

  // Width of every offset and length field on the result.
  localparam int unsigned FieldW = 12;

  // Byte codes
  localparam logic [7:0] ChHt    = 8'h09;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChColon = 8'h3A;

  // Line length limit after reset
  localparam logic [FieldW-1:0] MaxLenReset = 12'd1024;

  typedef enum logic [1:0] {
    STATUS_FIELD = 2'd0,
    STATUS_END   = 2'd1,
    STATUS_BAD   = 2'd2,
    STATUS_LARGE = 2'd3
  } status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       new_message;
  } in_t;

  typedef struct packed {
    status_e           status;
    logic [FieldW-1:0] name_start;
    logic [FieldW-1:0] name_length;
    logic [FieldW-1:0] value_start;
    logic [FieldW-1:0] value_length;
  } out_t;

endpackage

@@ src/hhlp_in_reg.sv @@
module hhlp_in_reg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  hhlp_pkg::in_t in_data_i,
  output logic          item_valid_o,
  output hhlp_pkg::in_t item_o,
  input  logic          item_take_i
);
  import hhlp_pkg::*;

  logic in_valid_q;
  in_t  in_q;
  logic accept;

  // Stall only while the held byte cannot move on this cycle
  assign in_stall_o   = in_valid_q && !item_take_i;
  assign accept       = in_valid_i && !in_stall_o;
  assign item_valid_o = in_valid_q;
  assign item_o       = in_q;

  // Track occupancy of the input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (accept) begin
      in_valid_q <= 1'b1;
    end else if (item_take_i) begin
      in_valid_q <= 1'b0;
    end
  end

  // Capture the byte on each input transfer
  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_data_i;
    end
  end

endmodule

@@ src/hhlp_line_core.sv @@
module hhlp_line_core #(
  parameter int unsigned POSITION_BITS = 12
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  input  logic [hhlp_pkg::FieldW-1:0] cfg_data_i,
  input  logic                        item_valid_i,
  input  hhlp_pkg::in_t               item_i,
  output logic                        item_take_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output hhlp_pkg::out_t              out_data_o
);
  import hhlp_pkg::*;

  localparam int unsigned PosW  = POSITION_BITS;
  localparam int unsigned WideW = (PosW + 1 > FieldW) ? PosW + 1 : FieldW;
  localparam logic [PosW-1:0] PosMax = {PosW{1'b1}};

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_ENDED,
    PH_STOPPED
  } phase_e;

  phase_e            phase_q, phase_d, eff_phase;
  logic              cr_q, cr_d, eff_cr;
  logic [PosW-1:0]   pos_q, pos_d, eff_pos;
  logic [PosW-1:0]   nf_q, nf_d, eff_nf;
  logic [PosW-1:0]   nl_q, nl_d, eff_nl;
  logic              colon_q, colon_d, eff_colon;
  logic [PosW-1:0]   vf_q, vf_d, eff_vf;
  logic [PosW-1:0]   vl_q, vl_d, eff_vl;
  logic              ns_q, ns_d, eff_ns;
  logic              vs_q, vs_d, eff_vs;
  logic [FieldW-1:0] max_len_q;
  logic              out_valid_q, out_valid_d;
  out_t              out_q, out_d;
  logic              emit;

  logic [7:0]        c;
  logic              blank;
  logic              too_long;
  logic [PosW:0]     name_len_n, value_len_n;
  logic [WideW-1:0]  name_len_w, value_len_w, nf_w, vf_w, pos_w, max_w;

  // Move a byte through whenever the result register can take its result
  assign item_take_o = item_valid_i && (!out_valid_q || !out_stall_i);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Restart a header block ahead of the byte that asks for it
  always_comb begin
    if (item_i.new_message) begin
      eff_phase = PH_HEADER;
      eff_cr    = 1'b0;
      eff_pos   = '0;
      eff_nf    = '0;
      eff_nl    = '0;
      eff_colon = 1'b0;
      eff_vf    = '0;
      eff_vl    = '0;
      eff_ns    = 1'b0;
      eff_vs    = 1'b0;
    end else begin
      eff_phase = phase_q;
      eff_cr    = cr_q;
      eff_pos   = pos_q;
      eff_nf    = nf_q;
      eff_nl    = nl_q;
      eff_colon = colon_q;
      eff_vf    = vf_q;
      eff_vl    = vl_q;
      eff_ns    = ns_q;
      eff_vs    = vs_q;
    end
  end

  // Classify the byte and size the field spans
  assign c           = item_i.data_byte;
  assign blank       = (c == ChSpace) || (c >= ChHt && c <= ChCr);
  assign pos_w       = WideW'(eff_pos);
  assign max_w       = WideW'(max_len_q);
  assign too_long    = (pos_w > max_w) || (eff_pos == PosMax);
  assign name_len_n  = {1'b0, eff_nl} - {1'b0, eff_nf} + (PosW+1)'(1);
  assign value_len_n = {1'b0, eff_vl} - {1'b0, eff_vf} + (PosW+1)'(1);
  assign name_len_w  = WideW'(name_len_n);
  assign value_len_w = WideW'(value_len_n);
  assign nf_w        = WideW'(eff_nf);
  assign vf_w        = WideW'(eff_vf);

  // Next parse state and result for the byte in the input register
  always_comb begin
    phase_d = phase_q;
    cr_d    = cr_q;
    pos_d   = pos_q;
    nf_d    = nf_q;
    nl_d    = nl_q;
    colon_d = colon_q;
    vf_d    = vf_q;
    vl_d    = vl_q;
    ns_d    = ns_q;
    vs_d    = vs_q;
    emit    = 1'b0;
    out_d   = '0;
    if (item_take_o) begin
      phase_d = eff_phase;
      cr_d    = eff_cr;
      pos_d   = eff_pos;
      nf_d    = eff_nf;
      nl_d    = eff_nl;
      colon_d = eff_colon;
      vf_d    = eff_vf;
      vl_d    = eff_vl;
      ns_d    = eff_ns;
      vs_d    = eff_vs;
      if (eff_phase == PH_HEADER) begin
        if (c == ChLf) begin
          emit = 1'b1;
          priority if (!eff_cr) begin
            phase_d      = PH_STOPPED;
            out_d.status = STATUS_BAD;
          end else if (too_long) begin
            phase_d      = PH_STOPPED;
            out_d.status = STATUS_LARGE;
          end else if (eff_pos == PosW'(1)) begin
            phase_d      = PH_ENDED;
            out_d.status = STATUS_END;
          end else if (!eff_ns || !eff_colon || !eff_vs ||
                       (eff_nl < eff_nf) || (eff_vl < eff_vf)) begin
            phase_d      = PH_STOPPED;
            out_d.status = STATUS_BAD;
          end else begin
            out_d.status       = STATUS_FIELD;
            out_d.name_start   = nf_w[FieldW-1:0];
            out_d.name_length  = name_len_w[FieldW-1:0];
            out_d.value_start  = vf_w[FieldW-1:0];
            out_d.value_length = value_len_w[FieldW-1:0];
          end
          // Clear the line after any CR LF line that is not too large
          if (eff_cr && !too_long) begin
            cr_d    = 1'b0;
            pos_d   = '0;
            nf_d    = '0;
            nl_d    = '0;
            colon_d = 1'b0;
            vf_d    = '0;
            vl_d    = '0;
            ns_d    = 1'b0;
            vs_d    = 1'b0;
          end
        end else begin
          // Track name and value bounds inside the line
          priority if (!eff_ns) begin
            if (!blank) begin
              ns_d = 1'b1;
              nf_d = eff_pos;
              nl_d = eff_pos;
            end
          end else if (!eff_colon) begin
            if (c == ChColon) begin
              colon_d = 1'b1;
            end else if (!blank) begin
              nl_d = eff_pos;
            end
          end else if (!blank) begin
            if (!eff_vs) begin
              vs_d = 1'b1;
              vf_d = eff_pos;
            end
            vl_d = eff_pos;
          end
          cr_d = (c == ChCr);
          if (eff_pos != PosMax) begin
            pos_d = eff_pos + PosW'(1);
          end
        end
      end
    end
  end

  // Hold a result until the output transfer, then load the next one
  always_comb begin
    out_valid_d = out_valid_q;
    if (!out_valid_q || !out_stall_i) begin
      out_valid_d = item_take_o && emit;
    end
  end

  // Parse state, limit register and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HEADER;
      cr_q        <= 1'b0;
      pos_q       <= '0;
      nf_q        <= '0;
      nl_q        <= '0;
      colon_q     <= 1'b0;
      vf_q        <= '0;
      vl_q        <= '0;
      ns_q        <= 1'b0;
      vs_q        <= 1'b0;
      max_len_q   <= MaxLenReset;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      cr_q        <= cr_d;
      pos_q       <= pos_d;
      nf_q        <= nf_d;
      nl_q        <= nl_d;
      colon_q     <= colon_d;
      vf_q        <= vf_d;
      vl_q        <= vl_d;
      ns_q        <= ns_d;
      vs_q        <= vs_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        max_len_q <= cfg_data_i;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (item_take_o && emit) begin
      out_q <= out_d;
    end
  end

endmodule

@@ src/http_header_line_parser.sv @@
// HTTP header line parser.
// Input channel (in_valid_i / in_stall_o / in_data_i) takes one header byte per
// transfer, with new_message set on the first byte of a header block. At an
// LF the block sends one result on the output channel (out_valid_o /
// out_stall_i / out_data_o): a field line with name and value offsets and
// trimmed lengths, the end of headers, a bad request or a line too large.
// After the end of headers or an error, bytes are dropped until new_message.
// Throughput: one byte per cycle while the result is not stalled. The result
// of an LF byte passes through the input register, then the result register;
// the parse state update sits between them.
// A stalled result holds in the result register; the input register keeps
// taking bytes until it holds one that cannot move on, then in_stall_o rises.
// The configuration channel (cfg_valid_i / cfg_ready_o / cfg_data_i) writes the
// line length limit; it is always ready and should be written while idle.
// Reset clears the parse state to the start of a header block, sets the limit
// to 1024 bytes and empties both registers.
module http_header_line_parser #(
  parameter int unsigned POSITION_BITS = 12
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [hhlp_pkg::FieldW-1:0] cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  hhlp_pkg::in_t               in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output hhlp_pkg::out_t              out_data_o
);
  import hhlp_pkg::*;

  logic item_valid;
  in_t  item;
  logic item_take;

  assign cfg_ready_o = 1'b1;

  // Input register
  hhlp_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_data_i    (in_data_i),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_take_i  (item_take)
  );

  // Parse state and result register
  hhlp_line_core #(
    .POSITION_BITS (POSITION_BITS)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_data_i   (cfg_data_i),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_take_o  (item_take),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

endmodule

@@ src/hhlp_checker.sv @@
`include "assert_macros.svh"

module hhlp_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_stall_o,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input hhlp_pkg::out_t out_data_o
);
  import hhlp_pkg::*;

  logic res_field;
  logic res_spans_zero;
  logic res_ordered;

  // Classify the offered result
  assign res_field      = out_data_o.status == STATUS_FIELD;
  assign res_spans_zero = (out_data_o.name_start == '0) && (out_data_o.name_length == '0) &&
                          (out_data_o.value_start == '0) && (out_data_o.value_length == '0);
  assign res_ordered    = (out_data_o.value_start > out_data_o.name_start) ||
                          (out_data_o.name_length == '0);

  // A stalled result stays offered
  `ASSERT_PROP(a_out_valid_held, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o)

  // A stalled result keeps its payload
  `ASSERT_HOLD(a_out_data_held, clk_i, rst_ni, out_valid_o && out_stall_i, out_data_o)

  // Only field lines carry offsets and lengths
  `ASSERT_PROP(a_nonfield_zero, clk_i, rst_ni, out_valid_o && !res_field |-> res_spans_zero)

  // A field line's value starts after its name starts
  `ASSERT_PROP(a_field_order, clk_i, rst_ni, out_valid_o && res_field |-> res_ordered)

  // The input stalls only behind a stalled result
  `ASSERT_PROP(a_in_stall_cause, clk_i, rst_ni, in_stall_o |-> out_valid_o && out_stall_i)

endmodule

bind http_header_line_parser hhlp_checker u_hhlp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

@@ dv/http_header_checker.sv @@
`timescale 1ns / 1ps

module http_header_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  input  logic                        cfg_ready_i,
  input  logic [hhlp_pkg::FieldW-1:0] cfg_data_i,
  input  logic                        in_valid_i,
  input  logic                        in_stall_i,
  input  hhlp_pkg::in_t               in_data_i,
  input  logic                        out_valid_i,
  input  logic                        out_stall_i,
  input  hhlp_pkg::out_t              out_data_i,
  output int                          fail_count_o,
  output int                          pending_o
);
  import hhlp_pkg::*;

  typedef enum logic [1:0] {
    PHASE_HEADER,
    PHASE_ENDED,
    PHASE_STOPPED
  } phase_e;

  // Line position saturates here; a CR LF line that reaches it is always too large.
  localparam int unsigned PosMax = (1 << FieldW) - 1;

  // Predicted parser state
  phase_e            phase;
  logic [FieldW-1:0] line_limit;
  bit                after_cr;
  logic [FieldW-1:0] line_pos;
  logic [FieldW-1:0] name_lo;
  logic [FieldW-1:0] name_hi;
  logic [FieldW-1:0] value_lo;
  logic [FieldW-1:0] value_hi;
  bit                got_name;
  bit                got_colon;
  bit                got_value;

  out_t expected_lines_q[$];
  int   result_count;

  function automatic bit is_blank(logic [7:0] c);
    return c == ChSpace || (c >= ChHt && c <= ChCr);
  endfunction

  task automatic clear_line();
    after_cr  = 1'b0;
    line_pos  = '0;
    name_lo   = '0;
    name_hi   = '0;
    value_lo  = '0;
    value_hi  = '0;
    got_name  = 1'b0;
    got_colon = 1'b0;
    got_value = 1'b0;
  endtask

  // Advance the parse state by one byte and queue the line result it causes.
  task automatic parse_byte(input in_t item);
    out_t       res;
    bit         has_result;
    logic [7:0] c;
    c          = item.data_byte;
    res        = '0;
    has_result = 1'b0;
    if (item.new_message) begin
      phase = PHASE_HEADER;
      clear_line();
    end
    if (phase == PHASE_HEADER) begin
      if (c == ChLf) begin
        has_result = 1'b1;
        if (!after_cr) begin
          phase      = PHASE_STOPPED;
          res.status = STATUS_BAD;
        end else if (line_pos > line_limit || line_pos >= PosMax) begin
          phase      = PHASE_STOPPED;
          res.status = STATUS_LARGE;
        end else if (line_pos == 1) begin
          phase      = PHASE_ENDED;
          res.status = STATUS_END;
          clear_line();
        end else if (!got_name || !got_colon || !got_value ||
                     name_hi < name_lo || value_hi < value_lo) begin
          phase      = PHASE_STOPPED;
          res.status = STATUS_BAD;
        end else begin
          res.status       = STATUS_FIELD;
          res.name_start   = name_lo;
          res.name_length  = name_hi - name_lo + 1'b1;
          res.value_start  = value_lo;
          res.value_length = value_hi - value_lo + 1'b1;
          clear_line();
        end
      end else begin
        // Track name and value bounds, trimming blanks on both sides
        if (!got_name) begin
          if (!is_blank(c)) begin
            got_name = 1'b1;
            name_lo  = line_pos;
            name_hi  = line_pos;
          end
        end else if (!got_colon) begin
          if (c == ChColon) got_colon = 1'b1;
          else if (!is_blank(c)) name_hi = line_pos;
        end else if (!is_blank(c)) begin
          if (!got_value) begin
            got_value = 1'b1;
            value_lo  = line_pos;
          end
          value_hi = line_pos;
        end
        after_cr = (c == ChCr);
        if (line_pos < PosMax) line_pos = line_pos + 1'b1;
      end
    end
    if (has_result) expected_lines_q.push_back(res);
  endtask

  // Compare one result transfer with the oldest expected line result.
  task automatic check_line_result(input out_t got);
    out_t exp;
    bit   bad;
    if (expected_lines_q.size() == 0) begin
      fail_count_o++;
      if (fail_count_o <= 10)
        $display("%0t: result %0d arrived with nothing expected: st=%0d ns=%0d nl=%0d vs=%0d vl=%0d",
                 $realtime, result_count, got.status, got.name_start, got.name_length,
                 got.value_start, got.value_length);
    end else begin
      exp = expected_lines_q.pop_front();
      bad = (got.status !== exp.status) || (got.name_start !== exp.name_start) ||
            (got.name_length !== exp.name_length) || (got.value_start !== exp.value_start) ||
            (got.value_length !== exp.value_length);
      if (bad) begin
        fail_count_o++;
        if (fail_count_o <= 10)
          $display("%0t: result %0d mismatch: exp st=%0d ns=%0d nl=%0d vs=%0d vl=%0d, got st=%0d ns=%0d nl=%0d vs=%0d vl=%0d",
                   $realtime, result_count, exp.status, exp.name_start, exp.name_length,
                   exp.value_start, exp.value_length, got.status, got.name_start,
                   got.name_length, got.value_start, got.value_length);
      end
    end
    result_count++;
  endtask

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
    result_count = 0;
  end

  // Watch the three channels; a register write applies before any byte
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase      = PHASE_HEADER;
      line_limit = MaxLenReset;
      clear_line();
      expected_lines_q.delete();
      pending_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) line_limit = cfg_data_i;
      if (out_valid_i && !out_stall_i) check_line_result(out_data_i);
      if (in_valid_i && !in_stall_i) parse_byte(in_data_i);
      pending_o = expected_lines_q.size();
    end
  end

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import hhlp_pkg::*;

  localparam int ByteGoal = 950;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [FieldW-1:0] cfg_data_i;
  logic              in_valid_i;
  logic              in_stall_o;
  in_t               in_data_i;
  logic              out_valid_o;
  logic              out_stall_i;
  out_t              out_data_o;

  int fail_count;
  int pending;

  int send_idle_pct;
  int recv_stall_pct;
  bit hold_req;
  bit hold_done;
  bit counting;
  int byte_count;
  int cur_limit;
  int phase_limit[5];

  http_header_line_parser i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  http_header_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .in_data_i    (in_data_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_i   (out_data_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Hard limit on the run
  initial begin
    #1000000;
    $display("tb_top: errors");
    $finish;
  end

  // Result receiver: random stall, or one long hold-off on request
  initial begin
    out_stall_i = 1'b0;
    hold_done   = 1'b0;
    @(negedge clk_i);
    forever begin
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        repeat (300) begin
          out_stall_i <= 1'b1;
          @(negedge clk_i);
        end
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_stall_pct);
        @(negedge clk_i);
      end
    end
  end

  function automatic logic [7:0] rand_blank();
    return $urandom_range(1) ? ChSpace : ChHt;
  endfunction

  function automatic logic [7:0] rand_token();
    logic [7:0] c;
    do c = 8'($urandom_range(33, 126)); while (c == ChColon);
    return c;
  endfunction

  function automatic logic [7:0] rand_value_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(255)); while (c == ChLf);
    return c;
  endfunction

  // Offer one byte, idling at random first; return once it is transferred
  task automatic send_byte(input logic [7:0] b, input bit restart);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i            <= 1'b1;
    in_data_i.data_byte   <= b;
    in_data_i.new_message <= restart;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
    if (counting) byte_count++;
  endtask

  task automatic send_text(input string s, input bit restart);
    bit r;
    r = restart;
    for (int i = 0; i < s.len(); i++) begin
      send_byte(s[i], r);
      r = 1'b0;
    end
  endtask

  task automatic send_line(input string s, input bit restart);
    send_text(s, restart);
    send_byte(ChCr, restart && s.len() == 0);
    send_byte(ChLf, 1'b0);
  endtask

  // Drop valid and wait until every expected line result has come
  task automatic settle();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_limit(input int v);
    settle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v[FieldW-1:0];
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    cur_limit = v;
  endtask

  // Well-formed field line with random blanks, name and value
  task automatic send_field_line(input bit restart);
    bit r;
    int n;
    r = restart;
    n = $urandom_range(0, 2);
    repeat (n) begin
      send_byte(rand_blank(), r);
      r = 1'b0;
    end
    if ($urandom_range(9) == 0) begin
      send_byte(ChColon, r);
      r = 1'b0;
    end
    n = $urandom_range(1, 8);
    repeat (n) begin
      send_byte(rand_token(), r);
      r = 1'b0;
    end
    repeat ($urandom_range(0, 2)) send_byte(rand_blank(), 1'b0);
    send_byte(ChColon, 1'b0);
    repeat ($urandom_range(0, 3)) send_byte(rand_blank(), 1'b0);
    send_byte(rand_token(), 1'b0);
    n = ($urandom_range(19) == 0) ? $urandom_range(20, 200) : $urandom_range(0, 20);
    repeat (n) send_byte(rand_value_byte(), 1'b0);
    repeat ($urandom_range(0, 2)) send_byte(rand_blank(), 1'b0);
    send_byte(ChCr, 1'b0);
    send_byte(ChLf, 1'b0);
  endtask

  // Line that stops the header block with an error
  task automatic send_broken_line(input bit restart);
    int kind;
    kind = $urandom_range(4);
    if (kind == 4 && cur_limit > 300) kind = 1;
    case (kind)
      0: begin
        // bare LF
        send_byte(rand_token(), restart);
        send_byte(ChColon, 1'b0);
        send_byte(rand_token(), 1'b0);
        send_byte(ChLf, 1'b0);
      end
      1: begin
        // no colon
        send_byte(rand_token(), restart);
        repeat ($urandom_range(0, 5)) send_byte(rand_token(), 1'b0);
        send_byte(ChCr, 1'b0);
        send_byte(ChLf, 1'b0);
      end
      2: begin
        // blanks only, so no name
        send_byte(rand_blank(), restart);
        repeat ($urandom_range(0, 2)) send_byte(rand_blank(), 1'b0);
        send_byte(ChCr, 1'b0);
        send_byte(ChLf, 1'b0);
      end
      3: begin
        // no value
        send_byte(rand_token(), restart);
        send_byte(ChColon, 1'b0);
        repeat ($urandom_range(0, 3)) send_byte(rand_blank(), 1'b0);
        send_byte(ChCr, 1'b0);
        send_byte(ChLf, 1'b0);
      end
      default: begin
        // just past the line limit
        send_byte(rand_token(), restart);
        send_byte(ChColon, 1'b0);
        repeat (cur_limit - 2 + $urandom_range(0, 3)) send_byte(rand_value_byte(), 1'b0);
        send_byte(ChCr, 1'b0);
        send_byte(ChLf, 1'b0);
      end
    endcase
  endtask

  // Random bytes, now and then a restart inside, closed by CR LF
  task automatic send_noise_line(input bit restart);
    send_byte(8'($urandom_range(255)), restart);
    repeat ($urandom_range(0, 11))
      send_byte(8'($urandom_range(255)), $urandom_range(99) < 3);
    send_byte(ChCr, 1'b0);
    send_byte(ChLf, 1'b0);
  endtask

  task automatic send_random_message();
    int  lines;
    int  kind;
    bit  first;
    lines = $urandom_range(0, 5);
    first = 1'b1;
    for (int i = 0; i < lines; i++) begin
      kind = $urandom_range(99);
      if (kind < 75) begin
        send_field_line(first);
      end else if (kind < 90) begin
        send_broken_line(first);
        return;
      end else begin
        send_noise_line(first);
      end
      first = 1'b0;
    end
    send_line("", first);
    // trailing bytes after the end are dropped by the block
    if ($urandom_range(99) < 30) begin
      counting = 1'b0;
      repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(255)), 1'b0);
      counting = 1'b1;
    end
  endtask

  initial begin
    rst_ni         = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_data_i     = '0;
    in_valid_i     = 1'b0;
    in_data_i      = '0;
    send_idle_pct  = 20;
    recv_stall_pct = 20;
    hold_req       = 1'b0;
    counting       = 1'b1;
    byte_count     = 0;
    cur_limit      = int'(MaxLenReset);
    phase_limit    = '{1024, 16, 4095, 0, 40};

    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: trimming, leading colon, CR inside a line, end of headers
    send_line("Host: ab", 1'b1);
    send_line("  X-A\t : v1 v2 \t", 1'b0);
    send_line(":authority: x", 1'b0);
    send_line("K::v", 1'b0);
    send_line("A:b\015c", 1'b0);
    send_line("", 1'b0);
    send_line("Z: dropped", 1'b0);
    // Errors, each in a block of its own
    send_text("A:b", 1'b1);
    send_byte(ChLf, 1'b0);
    send_line("NoColon", 1'b1);
    send_line(" \t ", 1'b1);
    send_line("N: \t", 1'b1);
    send_line(":", 1'b1);
    // Restart in the middle of a line
    send_text("Partial he", 1'b1);
    send_line("Q: r", 1'b1);
    send_line("", 1'b0);
    send_line("\377\200:\177\001", 1'b1);

    // Shortest limit: one line fits exactly, the next is one byte over
    write_limit(16);
    send_line("Abc: 0123456789", 1'b1);
    send_line("Abcd: 0123456789", 1'b0);

    // Random phases, each with its own limit
    for (int p = 0; p < 5; p++) begin
      write_limit(p == 3 ? $urandom_range(17, 80) : phase_limit[p]);
      send_idle_pct  = (p == 2) ? 0 : 20;
      recv_stall_pct = (p == 2) ? 0 : 20;
      if (p == 3) hold_req = 1'b1;
      while (byte_count < ByteGoal * (p + 1) / 5) send_random_message();
    end

    // Drain and give the verdict
    settle();
    repeat (10) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
